// ----- rtl/qdr_pkg.sv -----
// Shared widths, constants and payload types for the quaternion delta rotation block.
package qdr_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int D_W       = PROD_W + 2;
  localparam int NORM_BITS = (58 - FRAC_BITS) / 2;
  localparam int NV_W      = NORM_BITS + 1;
  localparam int SQ_W      = 2 * NV_W;
  localparam int N2_W      = SQ_W + 1;
  localparam int NUM_W     = SQ_W + 2;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int REM_W     = NUM_W + Q_W;
  localparam int DSH_W     = REM_W - 1;
  localparam int LEN_W     = 6;
  localparam int N_ENT     = 9;

  localparam logic [LEN_W-1:0]     LEN_NORM = LEN_W'(NORM_BITS);
  localparam logic [WORD_BITS-1:0] ONE_WORD = WORD_BITS'(1 << FRAC_BITS);

  typedef struct packed {
    logic [WORD_BITS-1:0] rx, ry, rz, rw;
    logic                 lvalid;
    logic [WORD_BITS-1:0] lx, ly, lz, lw;
  } in_t;

  typedef struct packed {
    logic signed [NV_W-1:0] x, y, z, w;
    logic                   degen;
  } norm_t;

  typedef struct packed {
    logic [N_ENT-1:0][REM_W-1:0] rem;
    logic [N_ENT-1:0][Q_W-1:0]   quo;
    logic [N_ENT-1:0]            neg;
    logic [DSH_W-1:0]            dsh;
    logic                        degen;
  } div_t;

endpackage

// ----- rtl/qdr_in_if.sv -----
// Input channel: rendered and latest orientation quaternions.
interface qdr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qdr_pkg::WORD_BITS-1:0] rendered_x, rendered_y, rendered_z, rendered_w;
  logic                                 latest_valid;
  logic signed [qdr_pkg::WORD_BITS-1:0] latest_x, latest_y, latest_z, latest_w;

  modport source (output valid, rendered_x, rendered_y, rendered_z, rendered_w,
                  latest_valid, latest_x, latest_y, latest_z, latest_w, input ready);
  modport sink   (input valid, rendered_x, rendered_y, rendered_z, rendered_w,
                  latest_valid, latest_x, latest_y, latest_z, latest_w, output ready);
endinterface

// ----- rtl/qdr_out_if.sv -----
// Output channel: rotation matrix entries and degenerate flag.
interface qdr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qdr_pkg::WORD_BITS-1:0] m_row0_col0, m_row0_col1, m_row0_col2;
  logic signed [qdr_pkg::WORD_BITS-1:0] m_row1_col0, m_row1_col1, m_row1_col2;
  logic signed [qdr_pkg::WORD_BITS-1:0] m_row2_col0, m_row2_col1, m_row2_col2;
  logic                                 degenerate;

  modport source (output valid, m_row0_col0, m_row0_col1, m_row0_col2, m_row1_col0,
                  m_row1_col1, m_row1_col2, m_row2_col0, m_row2_col1, m_row2_col2,
                  degenerate, input ready);
  modport sink   (input valid, m_row0_col0, m_row0_col1, m_row0_col2, m_row1_col0,
                  m_row1_col1, m_row1_col2, m_row2_col0, m_row2_col1, m_row2_col2,
                  degenerate, output ready);
endinterface

// ----- rtl/qdr_front.sv -----
// Difference quaternion, block-scale search and normalizing shift (four stages).
module qdr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vin,
  input  qdr_pkg::in_t        din,
  output logic                vout,
  output qdr_pkg::norm_t      dout
);

  localparam int W = qdr_pkg::WORD_BITS;
  localparam int P = qdr_pkg::PROD_W;
  localparam int D = qdr_pkg::D_W;
  localparam int L = qdr_pkg::LEN_W;
  localparam int NB = qdr_pkg::NORM_BITS;

  logic v1, v2, v3;

  // stage 1: 16 partial products, index [latest][rendered], order x y z w
  logic signed [W-1:0] lq [4];
  logic signed [W-1:0] rq [4];
  logic signed [P-1:0] p [4][4];

  always_comb begin
    rq[0] = din.rx; rq[1] = din.ry; rq[2] = din.rz; rq[3] = din.rw;
    if (din.lvalid) begin
      lq[0] = din.lx; lq[1] = din.ly; lq[2] = din.lz; lq[3] = din.lw;
    end else begin
      lq[0] = '0; lq[1] = '0; lq[2] = '0; lq[3] = qdr_pkg::ONE_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          p[i][j] <= lq[i] * rq[j];
    end
  end

  // stage 2: d = l * conj(r)
  logic signed [D-1:0] d [4];
  function automatic logic signed [D-1:0] ex(input logic signed [P-1:0] a);
    ex = D'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      d[0] <= -ex(p[3][0]) + ex(p[0][3]) - ex(p[1][2]) + ex(p[2][1]);
      d[1] <= -ex(p[3][1]) + ex(p[0][2]) + ex(p[1][3]) - ex(p[2][0]);
      d[2] <= -ex(p[3][2]) - ex(p[0][1]) + ex(p[1][0]) + ex(p[2][3]);
      d[3] <=  ex(p[3][3]) + ex(p[0][0]) + ex(p[1][1]) + ex(p[2][2]);
    end
  end

  // stage 3: sign/magnitude; bit length of the largest is that of the OR
  logic [D-1:0] mg_c [4];
  logic [D-1:0] orv;
  logic [L-1:0] len_c;
  logic [D-1:0] mg [4];
  logic [3:0]   ng;
  logic [L-1:0] len;

  always_comb begin
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      mg_c[i] = d[i][D-1] ? D'(-d[i]) : D'(d[i]);
      orv = orv | mg_c[i];
    end
    len_c = '0;
    for (int b = 0; b < D; b++)
      if (orv[b]) len_c = L'(b + 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mg[i] <= mg_c[i];
        ng[i] <= d[i][D-1];
      end
      len <= len_c;
    end
  end

  // stage 4: shift all four so the bit length becomes NORM_BITS
  logic [D-1:0]            sh [4];
  logic signed [NB:0]      nv [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (len > qdr_pkg::LEN_NORM) sh[i] = mg[i] >> (len - qdr_pkg::LEN_NORM);
      else                         sh[i] = mg[i] << (qdr_pkg::LEN_NORM - len);
      nv[i] = ng[i] ? -$signed({1'b0, sh[i][NB-1:0]}) : $signed({1'b0, sh[i][NB-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.x     <= nv[0];
      dout.y     <= nv[1];
      dout.z     <= nv[2];
      dout.w     <= nv[3];
      dout.degen <= (len == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; vout <= 1'b0;
    end else if (en) begin
      v1 <= vin; v2 <= v1; v3 <= v2; vout <= v3;
    end
  end

endmodule

// ----- rtl/qdr_matrix.sv -----
// Homogeneous matrix terms, squared norm and divider setup (two stages).
module qdr_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vin,
  input  qdr_pkg::norm_t      din,
  output logic                vout,
  output qdr_pkg::div_t       dout
);

  localparam int S  = qdr_pkg::SQ_W;
  localparam int NW = qdr_pkg::NUM_W;
  localparam int RW = qdr_pkg::REM_W;
  localparam int DW = qdr_pkg::DSH_W;
  localparam int N2 = qdr_pkg::N2_W;

  logic v5;
  logic signed [S-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  logic                dg5;

  always_ff @(posedge clk) begin
    if (en) begin
      xx <= din.x * din.x; yy <= din.y * din.y;
      zz <= din.z * din.z; ww <= din.w * din.w;
      xy <= din.x * din.y; xz <= din.x * din.z; yz <= din.y * din.z;
      wx <= din.w * din.x; wy <= din.w * din.y; wz <= din.w * din.z;
      dg5 <= din.degen;
    end
  end

  function automatic logic signed [NW-1:0] ex(input logic signed [S-1:0] a);
    ex = NW'(a);
  endfunction

  logic signed [NW-1:0] num [qdr_pkg::N_ENT];
  logic [N2-1:0]        n2;
  logic [NW-1:0]        mag [qdr_pkg::N_ENT];

  always_comb begin
    n2 = N2'(xx) + N2'(yy) + N2'(zz) + N2'(ww);
    num[0] = ex(ww) + ex(xx) - ex(yy) - ex(zz);
    num[1] = (ex(xy) - ex(wz)) <<< 1;
    num[2] = (ex(xz) + ex(wy)) <<< 1;
    num[3] = (ex(xy) + ex(wz)) <<< 1;
    num[4] = ex(ww) - ex(xx) + ex(yy) - ex(zz);
    num[5] = (ex(yz) - ex(wx)) <<< 1;
    num[6] = (ex(xz) - ex(wy)) <<< 1;
    num[7] = (ex(yz) + ex(wx)) <<< 1;
    num[8] = ex(ww) - ex(xx) - ex(yy) + ex(zz);
    for (int i = 0; i < qdr_pkg::N_ENT; i++)
      mag[i] = num[i][NW-1] ? NW'(-num[i]) : NW'(num[i]);
  end

  // dividend = |num| * 2^(F+1) + n2, divisor 2*n2 aligned to the top quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < qdr_pkg::N_ENT; i++) begin
        dout.rem[i] <= (RW'(mag[i]) << qdr_pkg::Q_W) + RW'(n2);
        dout.quo[i] <= '0;
        dout.neg[i] <= num[i][NW-1];
      end
      dout.dsh   <= DW'(n2) << qdr_pkg::Q_W;
      dout.degen <= dg5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0; vout <= 1'b0;
    end else if (en) begin
      v5 <= vin; vout <= v5;
    end
  end

endmodule

// ----- rtl/qdr_div_stage.sv -----
// One restoring-division step for all nine entries: one quotient bit.
module qdr_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vin,
  input  qdr_pkg::div_t       din,
  output logic                vout,
  output qdr_pkg::div_t       dout
);

  qdr_pkg::div_t nx;

  always_comb begin
    nx = din;
    for (int i = 0; i < qdr_pkg::N_ENT; i++) begin
      if (din.rem[i] >= {1'b0, din.dsh}) begin
        nx.rem[i] = din.rem[i] - {1'b0, din.dsh};
        nx.quo[i] = {din.quo[i][qdr_pkg::Q_W-2:0], 1'b1};
      end else begin
        nx.quo[i] = {din.quo[i][qdr_pkg::Q_W-2:0], 1'b0};
      end
    end
    nx.dsh = din.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nx;
  end

  always_ff @(posedge clk) begin
    if (rst)     vout <= 1'b0;
    else if (en) vout <= vin;
  end

endmodule

// ----- rtl/quaternion_delta_to_rotation_matrix.sv -----
// Top level: timewarp rotation matrix from rendered and latest orientation.
//
//   channel   dir  word contents
//   in_ch     in   rendered_{x,y,z,w}, latest_valid, latest_{x,y,z,w} (Q2.14)
//   out_ch    out  m_row{0..2}_col{0..2} (Q2.14), degenerate
//
// One word per cycle sustained while out_ch is not stalled; 4 front stages (products,
// sums, scale search, normalizing shift), 2 matrix stages, 15 divider stages
// (one quotient bit each, nine entries share the divisor).
// rst is synchronous; it clears the valid bits only.
// A stall at out_ch freezes every stage at once; in_ch.ready drops the same cycle.
module quaternion_delta_to_rotation_matrix (
  input logic        clk,
  input logic        rst,
  qdr_in_if.sink     in_ch,
  qdr_out_if.source  out_ch
);

  localparam int NS = qdr_pkg::Q_W;

  // global advance: the last register is empty or is being taken
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  qdr_pkg::in_t din;
  always_comb begin
    din.rx = in_ch.rendered_x; din.ry = in_ch.rendered_y;
    din.rz = in_ch.rendered_z; din.rw = in_ch.rendered_w;
    din.lvalid = in_ch.latest_valid;
    din.lx = in_ch.latest_x; din.ly = in_ch.latest_y;
    din.lz = in_ch.latest_z; din.lw = in_ch.latest_w;
  end

  logic           nv;
  qdr_pkg::norm_t nd;

  qdr_front u_front (
    .clk(clk), .rst(rst), .en(en), .vin(in_ch.valid), .din(din),
    .vout(nv), .dout(nd)
  );

  logic          dv [NS+1];
  qdr_pkg::div_t dd [NS+1];

  qdr_matrix u_matrix (
    .clk(clk), .rst(rst), .en(en), .vin(nv), .din(nd),
    .vout(dv[0]), .dout(dd[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_div
    qdr_div_stage u_stage (
      .clk(clk), .rst(rst), .en(en), .vin(dv[k]), .din(dd[k]),
      .vout(dv[k+1]), .dout(dd[k+1])
    );
  end

  // apply signs; a zero difference gives identity
  logic signed [qdr_pkg::WORD_BITS-1:0] ent [qdr_pkg::N_ENT];
  always_comb begin
    for (int i = 0; i < qdr_pkg::N_ENT; i++) begin
      if (dd[NS].degen)
        ent[i] = (i % 4 == 0) ? qdr_pkg::ONE_WORD : '0;
      else if (dd[NS].neg[i])
        ent[i] = -$signed(qdr_pkg::WORD_BITS'(dd[NS].quo[i]));
      else
        ent[i] = qdr_pkg::WORD_BITS'(dd[NS].quo[i]);
    end
  end

  assign out_ch.valid       = dv[NS];
  assign out_ch.m_row0_col0 = ent[0];
  assign out_ch.m_row0_col1 = ent[1];
  assign out_ch.m_row0_col2 = ent[2];
  assign out_ch.m_row1_col0 = ent[3];
  assign out_ch.m_row1_col1 = ent[4];
  assign out_ch.m_row1_col2 = ent[5];
  assign out_ch.m_row2_col0 = ent[6];
  assign out_ch.m_row2_col1 = ent[7];
  assign out_ch.m_row2_col2 = ent[8];
  assign out_ch.degenerate  = dd[NS].degen;

  // a stalled word is held by the frozen pipeline
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.m_row0_col1))
    else $error("output word lost during stall");

  a_degen_id: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.degenerate |->
      out_ch.m_row0_col0 == qdr_pkg::ONE_WORD && out_ch.m_row1_col2 == '0 &&
      out_ch.m_row2_col1 == '0)
    else $error("degenerate word is not identity");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");

endmodule
